// ----- src/pol_pkg.sv -----
// ----------------------------------------------------------------------------
// pol_pkg: shared types and codes for the positional ordered list
// Operation, status and cell-control codes, field widths.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int IDX_W   = 6;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [STAT_W-1:0]  status_t;

  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_DELETE = 2'd1;
  localparam func_t FUNC_DUMP   = 2'd2;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_RANGE = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  typedef logic [2:0] cell_op_t;

  localparam cell_op_t CELL_HOLD  = 3'd0;
  localparam cell_op_t CELL_LOAD  = 3'd1;
  localparam cell_op_t CELL_LEFT  = 3'd2;
  localparam cell_op_t CELL_RIGHT = 3'd3;
  localparam cell_op_t CELL_HEAD  = 3'd4;

endpackage

// ----- src/positional_ordered_list_core.sv -----
// ----------------------------------------------------------------------------
// positional_ordered_list_core: ordered list of signed 32-bit entries
// Insert, delete and dump by 1-based position over a chain of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells; an insert or delete shifts every
// affected cell by one place at once, so such a word gives one result word.
// A dump emits one result word per entry (one word for an empty list) by
// rotating the occupied cells past the head one place a cycle while the
// result register is free; the input is held off until the final dump word
// has been registered. A result register parts the two sides: a new input
// word is taken in the cycle its predecessor's result is taken. Status codes:
// 0 ok, 1 position out of range or unknown operation, 2 list full. Counts and
// indices are reported modulo 64.
// ----------------------------------------------------------------------------
module positional_ordered_list_core #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[7:0], value[39:8]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[1:0], entry_value[33:2],
                                  // entry_index[39:34], entry_count[45:40]
  output logic        out_tuser,  // item_valid[0]
  output logic        out_tlast
);
  import pol_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [8:0] CAP9 = 9'(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic            state_r,    state_nxt;
  logic [CW-1:0]   occ_r,      occ_nxt;
  logic [IW-1:0]   dump_idx_r, dump_idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic            out_item_r,   out_item_nxt;
  value_t          out_value_r,  out_value_nxt;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;
  logic [IDX_W-1:0] out_count_r, out_count_nxt;
  logic            out_last_r,   out_last_nxt;

  func_t           in_func;
  logic [POS_W-1:0] in_pos;
  value_t          in_val;
  logic [8:0]      pos9, occ9, idx9;
  logic            out_free, accept, dump_step, rotate;
  logic            ins_range, ins_full, ins_ok;
  logic            del_nop, del_range, del_ok;
  logic            do_ins, do_del;

  value_t          cell_q [CAPACITY];
  cell_op_t        cell_op [CAPACITY];

  assign in_func = in_tuser;
  assign in_pos  = in_tdata[7:0];
  assign in_val  = in_tdata[39:8];

  assign pos9 = {1'b0, in_pos};
  assign occ9 = 9'(occ_r);
  assign idx9 = 9'({1'b0, dump_idx_r} + 1'b1);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign dump_step = (state_r == ST_DUMP) && out_free;

  assign ins_range = (pos9 == 9'd0) || (pos9 > occ9 + 9'd1);
  assign ins_full  = occ9 >= CAP9;
  assign ins_ok    = !ins_range && !ins_full;
  assign del_nop   = (pos9 == 9'd1) && (occ9 == 9'd0);
  assign del_range = (pos9 == 9'd0) || (pos9 > occ9);
  assign del_ok    = !del_nop && !del_range;

  assign do_ins = accept && (in_func == FUNC_INSERT) && ins_ok;
  assign do_del = accept && (in_func == FUNC_DELETE) && del_ok;
  assign rotate = (accept && (in_func == FUNC_DUMP) && (occ9 != 9'd0)) || dump_step;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [8:0] I1 = 9'(i + 1);
    value_t left_val;
    value_t right_val;

    if (i == 0) begin : g_first
      assign left_val = cell_q[i];
    end else begin : g_mid_l
      assign left_val = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_q[i];
    end else begin : g_mid_r
      assign right_val = cell_q[i+1];
    end

    always_comb begin
      if (do_ins) begin
        if (pos9 == I1)     cell_op[i] = CELL_LOAD;
        else if (pos9 < I1) cell_op[i] = CELL_LEFT;
        else                cell_op[i] = CELL_HOLD;
      end else if (do_del) begin
        cell_op[i] = (pos9 <= I1) ? CELL_RIGHT : CELL_HOLD;
      end else if (rotate) begin
        cell_op[i] = (occ9 == I1) ? CELL_HEAD : CELL_RIGHT;
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end

    pol_cell u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .load_val  (in_val),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (cell_q[0]),
      .q         (cell_q[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    dump_idx_nxt   = dump_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_item_nxt   = 1'b0;
      out_value_nxt  = '0;
      out_index_nxt  = '0;
      out_last_nxt   = 1'b1;
      out_status_nxt = STATUS_OK;
      out_count_nxt  = IDX_W'(occ_r);
      case (in_func)
        FUNC_INSERT: begin
          if (ins_range) begin
            out_status_nxt = STATUS_RANGE;
          end else if (ins_full) begin
            out_status_nxt = STATUS_FULL;
          end else begin
            occ_nxt       = CW'(occ9 + 9'd1);
            out_count_nxt = IDX_W'(occ9 + 9'd1);
          end
        end
        FUNC_DELETE: begin
          if (del_range && !del_nop) begin
            out_status_nxt = STATUS_RANGE;
          end else if (del_ok) begin
            occ_nxt       = CW'(occ9 - 9'd1);
            out_count_nxt = IDX_W'(occ9 - 9'd1);
          end
        end
        FUNC_DUMP: begin
          if (occ9 != 9'd0) begin
            out_item_nxt  = 1'b1;
            out_value_nxt = cell_q[0];
            out_index_nxt = IDX_W'(1);
            out_last_nxt  = (occ9 == 9'd1);
            dump_idx_nxt  = IW'(1);
            if (occ9 != 9'd1) state_nxt = ST_DUMP;
          end
        end
        default: begin
          out_status_nxt = STATUS_RANGE;
        end
      endcase
    end else if (dump_step) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STATUS_OK;
      out_item_nxt   = 1'b1;
      out_value_nxt  = cell_q[0];
      out_index_nxt  = IDX_W'(idx9);
      out_count_nxt  = IDX_W'(occ_r);
      out_last_nxt   = (idx9 == occ9);
      dump_idx_nxt   = IW'(idx9);
      if (idx9 == occ9) state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_count_r, out_index_r, out_value_r, out_status_r};
  assign out_tuser  = out_item_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- src/pol_cell.sv -----
// ----------------------------------------------------------------------------
// pol_cell: one storage cell of the list chain
// Holds one entry; takes a new value, a neighbour's value or the head value.
// ----------------------------------------------------------------------------
module pol_cell (
  input  logic              clk,
  input  pol_pkg::cell_op_t op,
  input  pol_pkg::value_t   load_val,
  input  pol_pkg::value_t   left_val,
  input  pol_pkg::value_t   right_val,
  input  pol_pkg::value_t   head_val,
  output pol_pkg::value_t   q
);
  import pol_pkg::*;

  value_t val_r;
  value_t val_nxt;

  always_comb begin
    case (op)
      CELL_HOLD:  val_nxt = val_r;
      CELL_LOAD:  val_nxt = load_val;
      CELL_LEFT:  val_nxt = left_val;
      CELL_RIGHT: val_nxt = right_val;
      CELL_HEAD:  val_nxt = head_val;
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

// ----- src/pol_checker.sv -----
// ----------------------------------------------------------------------------
// pol_checker: port-level checks for the positional ordered list
// Watches the result stream and the input handshake over time.
// ----------------------------------------------------------------------------
module pol_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // drop input while a dump is still under way
  a_dump_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken during a dump");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  a_no_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[39:2] == 38'd0 && out_tlast)
    else $error("entry fields set on a non-entry word");

endmodule

bind positional_ordered_list_core pol_checker u_pol_checker (.*);
